[rtl/core/lkv_pkg.sv]
// lkv_pkg: shared types and constants for the lru key-value cache
// depends on nothing; imported by every module of the block but lkv_ram
package lkv_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int KEY_BITS_DEF   = 64;
	localparam int VALUE_BITS_DEF = 64;

	localparam int FIELD_W = 64;
	localparam int CAP_W   = 7;
	localparam int OCC_W   = 7;
	localparam int CNT32_W = 32;
	localparam int APB_AW  = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// register index on the apb port
	localparam logic REG_CAPACITY = 1'b0;

	// command codes
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_INVAL  = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [FIELD_W-1:0] key;
		logic [FIELD_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [FIELD_W-1:0] read_value;
		logic               evicted;
		logic [FIELD_W-1:0] evicted_key;
		logic [OCC_W-1:0]   occupancy;
		logic [CNT32_W-1:0] request_count;
		logic [CNT32_W-1:0] miss_count;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic walk_start;
		logic walk_step;
		logic age_phase;
		logic plan;
		logic commit;
	} lkv_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_last;
		logic need_age;
		logic out_free;
	} lkv_stat_t;

endpackage

[rtl/core/lkv_ram.sv]
// lkv_ram: generic simple dual-port ram, one write and one registered read
// depends on nothing
module lkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

[rtl/core/lkv_ctrl.sv]
// lkv_ctrl: sequencer for search walk, recency walk and result commit
// depends on lkv_pkg
module lkv_ctrl import lkv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  lkv_stat_t stat,
	output lkv_cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_SDRAIN, S_DECIDE, S_AGE, S_ADRAIN, S_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (req_valid) state_q <= S_SEARCH;
				S_SEARCH: if (stat.walk_last) state_q <= S_SDRAIN;
				S_SDRAIN: state_q <= S_DECIDE;
				S_DECIDE: state_q <= stat.need_age ? S_AGE : S_FINISH;
				S_AGE:    if (stat.walk_last) state_q <= S_ADRAIN;
				S_ADRAIN: state_q <= S_FINISH;
				S_FINISH: if (stat.out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load       = req_valid;
				cmd.walk_start = req_valid;
			end
			S_SEARCH: cmd.walk_step = 1'b1;
			S_SDRAIN: ;
			S_DECIDE: begin
				cmd.plan       = 1'b1;
				cmd.walk_start = 1'b1;
			end
			S_AGE: begin
				cmd.walk_step = 1'b1;
				cmd.age_phase = 1'b1;
			end
			S_ADRAIN: cmd.age_phase = 1'b1;
			S_FINISH: cmd.commit = stat.out_free;
			default: ;
		endcase
	end
endmodule

[rtl/core/lkv_datapath.sv]
// lkv_datapath: entry stores, search and recency walks, counters, result register
// depends on lkv_pkg and lkv_ram
module lkv_datapath import lkv_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	input  logic [CAP_W-1:0] capacity,
	input  lkv_cmd_t         cmd,
	output lkv_stat_t        stat,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp
);
	localparam int IW    = $clog2(DEPTH);
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [1:0]            cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] wval_q;

	logic [IW-1:0] idx_q;
	logic          rd_v_s1, rd_age_s1;
	logic [IW-1:0] rd_idx_s1;

	logic [DEPTH-1:0] valid_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT32_W-1:0] reqs_q, miss_q;

	logic                match_q, lru_v_q, free_v_q;
	logic [IW-1:0]       match_idx_q, lru_idx_q, free_idx_q;
	logic [AW-1:0]       match_age_q, lru_age_q;
	logic [KEY_BITS-1:0] lru_key_q;

	logic          evict_q, excl_q, inc_below_q, dec_above_q, inc_all_q;
	logic [IW-1:0] tgt_idx_q, ins_idx_q;
	logic [AW-1:0] tgt_age_q;

	logic                  out_v_q;
	rsp_t                  out_q;

	logic [KEY_BITS-1:0]   key_rdata;
	logic [AW-1:0]         age_rdata;
	logic [VALUE_BITS-1:0] val_rdata;

	logic                  is_lk, is_up, is_inv, evict;
	logic [CW-1:0]         cap_eff;
	logic                  walk_we;
	logic [AW-1:0]         age_new;
	logic                  age_we;
	logic [IW-1:0]         age_waddr;
	logic [AW-1:0]         age_wdata;
	logic                  ins_we;

	assign is_lk  = (cmd_q == CMD_LOOKUP);
	assign is_up  = (cmd_q == CMD_UPDATE);
	assign is_inv = (cmd_q == CMD_INVAL);

	always_comb begin
		if (capacity == '0) begin
			cap_eff = CW'(1);
		end else if (CW'(capacity) > CW'(DEPTH)) begin
			cap_eff = CW'(DEPTH);
		end else begin
			cap_eff = CW'(capacity);
		end
	end

	assign evict = is_up && !match_q && (CW'(count_q) >= cap_eff) && (count_q != '0);

	assign stat.walk_last = (idx_q == IW'(DEPTH - 1));
	assign stat.need_age  = is_up || (is_inv && match_q);
	assign stat.out_free  = !out_v_q || !rsp_stall;

	// recency update of one entry during the second walk
	always_comb begin
		age_new = age_rdata;
		if (inc_all_q) age_new = age_new + AW'(1);
		if (inc_below_q && (age_rdata < tgt_age_q)) age_new = age_new + AW'(1);
		if (dec_above_q && (age_rdata > tgt_age_q)) age_new = age_new - AW'(1);
	end

	assign walk_we = rd_v_s1 && rd_age_s1 && valid_q[rd_idx_s1]
		&& !(excl_q && (rd_idx_s1 == tgt_idx_q));
	assign ins_we  = cmd.commit && is_up && !match_q;

	always_comb begin
		age_we    = walk_we;
		age_waddr = rd_idx_s1;
		age_wdata = age_new;
		if (cmd.commit && is_up) begin
			age_we    = 1'b1;
			age_waddr = match_q ? match_idx_q : ins_idx_q;
			age_wdata = '0;
		end
	end

	lkv_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_keys (
		.clk(clk), .we(ins_we), .waddr(ins_idx_q), .wdata(key_q),
		.raddr(idx_q), .rdata(key_rdata)
	);

	lkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_values (
		.clk(clk), .we(cmd.commit && is_up),
		.waddr(match_q ? match_idx_q : ins_idx_q), .wdata(wval_q),
		.raddr(match_idx_q), .rdata(val_rdata)
	);

	lkv_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_ages (
		.clk(clk), .we(age_we), .waddr(age_waddr), .wdata(age_wdata),
		.raddr(idx_q), .rdata(age_rdata)
	);

	// payload and search registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= req.cmd;
			key_q    <= req.key[KEY_BITS-1:0];
			wval_q   <= req.write_value[VALUE_BITS-1:0];
		end
		if (cmd.walk_start) begin
			idx_q <= '0;
		end else if (cmd.walk_step) begin
			idx_q <= idx_q + IW'(1);
		end
		rd_idx_s1 <= idx_q;
		rd_age_s1 <= cmd.age_phase;
		if (rd_v_s1 && !rd_age_s1) begin
			if (valid_q[rd_idx_s1] && key_rdata == key_q && !match_q) begin
				match_idx_q <= rd_idx_s1;
				match_age_q <= age_rdata;
			end
			if (valid_q[rd_idx_s1] && (!lru_v_q || age_rdata > lru_age_q)) begin
				lru_idx_q <= rd_idx_s1;
				lru_age_q <= age_rdata;
				lru_key_q <= key_rdata;
			end
			if (!valid_q[rd_idx_s1] && !free_v_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
		if (cmd.plan) begin
			tgt_idx_q   <= match_q ? match_idx_q : lru_idx_q;
			tgt_age_q   <= match_q ? match_age_q : lru_age_q;
			// the evicted slot is free too; take the lower of the two
			if (evict && !(free_v_q && free_idx_q < lru_idx_q)) begin
				ins_idx_q <= lru_idx_q;
			end else begin
				ins_idx_q <= free_idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1     <= 1'b0;
			match_q     <= 1'b0;
			lru_v_q     <= 1'b0;
			free_v_q    <= 1'b0;
			evict_q     <= 1'b0;
			excl_q      <= 1'b0;
			inc_below_q <= 1'b0;
			dec_above_q <= 1'b0;
			inc_all_q   <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
			reqs_q      <= '0;
			miss_q      <= '0;
			out_v_q     <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.walk_step;
			if (cmd.load) begin
				match_q  <= 1'b0;
				lru_v_q  <= 1'b0;
				free_v_q <= 1'b0;
			end else if (rd_v_s1 && !rd_age_s1) begin
				if (valid_q[rd_idx_s1] && key_rdata == key_q) match_q <= 1'b1;
				if (valid_q[rd_idx_s1]) lru_v_q <= 1'b1;
				if (!valid_q[rd_idx_s1]) free_v_q <= 1'b1;
			end
			if (cmd.plan) begin
				evict_q     <= evict;
				excl_q      <= match_q || evict;
				inc_below_q <= is_up && match_q;
				dec_above_q <= (is_inv && match_q) || evict;
				inc_all_q   <= is_up && !match_q;
			end
			if (out_v_q && !rsp_stall) begin
				out_v_q <= 1'b0;
			end
			if (cmd.commit) begin
				out_v_q <= 1'b1;
				if (is_lk) begin
					reqs_q <= (reqs_q == '1) ? reqs_q : reqs_q + CNT32_W'(1);
					if (!match_q) miss_q <= (miss_q == '1) ? miss_q : miss_q + CNT32_W'(1);
				end
				if (is_inv && match_q) begin
					valid_q[match_idx_q] <= 1'b0;
					count_q <= count_q - CNT_W'(1);
				end
				if (is_up && !match_q) begin
					if (evict_q) valid_q[lru_idx_q] <= 1'b0;
					valid_q[ins_idx_q] <= 1'b1;
					if (!evict_q) count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.hit        <= match_q && (is_lk || is_up || is_inv);
			out_q.read_value <= (is_lk && match_q) ? FIELD_W'(val_rdata) : '0;
			out_q.evicted    <= is_up && evict_q;
			out_q.evicted_key <= (is_up && evict_q) ? FIELD_W'(lru_key_q) : '0;
			if (is_inv && match_q) begin
				out_q.occupancy <= OCC_W'(count_q - CNT_W'(1));
			end else if (is_up && !match_q && !evict_q) begin
				out_q.occupancy <= OCC_W'(count_q + CNT_W'(1));
			end else begin
				out_q.occupancy <= OCC_W'(count_q);
			end
			out_q.request_count <= (is_lk && reqs_q != '1) ? reqs_q + CNT32_W'(1) : reqs_q;
			out_q.miss_count <= (is_lk && !match_q && miss_q != '1)
				? miss_q + CNT32_W'(1) : miss_q;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("entry count differs from number of valid entries");

	a_commit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_v_q || !rsp_stall))
		else $error("result committed over an unread result");

	a_no_age_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(walk_we && cmd.commit))
		else $error("recency walk and commit write the age store together");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= DEPTH)
		else $error("entry count above depth");
endmodule

[rtl/core/lru_key_value_cache_unit.sv]
// lru_key_value_cache_unit: top level of the fully associative lru key-value cache
// depends on lkv_pkg, lkv_ctrl, lkv_datapath (and lkv_ram below it)
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+----------------------------
//  request | req_valid | req_stall | req (cmd, key, write_value)
//  result  | rsp_valid | rsp_stall | rsp (hit ... miss_count)
//  config  | apb write, psel/penable/pwrite, pready tied high
//
// each command runs a search walk over the key and age stores, one entry per cycle,
// then a recency walk over the age store (lookup, invalidate miss and cmd 3 skip it);
// the walks step one entry at a time, set by the single read port of each store.
// one command is in flight at a time; a new one is taken while a result waits.
// reset clears valid bits and counts and sets capacity to 64; no clearing pass.
// a stalled result holds the block in its last step until taken.
module lru_key_value_cache_unit import lkv_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	logic [CAP_W-1:0] cap_q;
	lkv_cmd_t         cmd;
	lkv_stat_t        stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : '0;

	lkv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.stat(stat), .cmd(cmd)
	);

	lkv_datapath #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .capacity(cap_q), .cmd(cmd),
		.stat(stat), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);
endmodule

[verif/lru_key_value_cache_unit_tb.sv]
// lru_key_value_cache_unit_tb: self-checking testbench for the lru key-value cache
// depends on lkv_pkg and lru_key_value_cache_unit; random commands checked against
// a behavioral cache kept here, with idling, stalls and capacity changes
module lru_key_value_cache_unit_tb;
	import lkv_pkg::*;

	localparam int SLOTS = 64;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_stall;
	rsp_t              rsp;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	lru_key_value_cache_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// behavioral cache state
	logic [63:0] line_key [SLOTS];
	logic [63:0] line_val [SLOTS];
	bit          line_vld [SLOTS];
	int unsigned line_rank [SLOTS];
	int unsigned line_cnt;
	logic [31:0] lookups_total;
	logic [31:0] lookups_failed;
	logic [6:0]  cap_reg;

	rsp_t        expected_words [$];
	int          error_count;
	longint      cycle_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_rsp;
	int          hold_cycles;
	logic [63:0] key_pool [16];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd3000000) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int find_line(logic [63:0] k);
		for (int i = 0; i < SLOTS; i++)
			if (line_vld[i] && line_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void drop_line(int s);
		int unsigned a;
		a = line_rank[s];
		line_vld[s] = 0;
		line_rank[s] = 0;
		for (int i = 0; i < SLOTS; i++)
			if (line_vld[i] && line_rank[i] > a) line_rank[i]--;
		if (line_cnt > 0) line_cnt--;
	endfunction

	function automatic rsp_t cache_access(req_t r);
		rsp_t o;
		int s, lru, fr;
		int unsigned a, cap;
		o = '0;
		cap = cap_reg;
		if (cap < 1) cap = 1;
		if (cap > SLOTS) cap = SLOTS;
		s = (r.cmd != CMD_SPARE) ? find_line(r.key) : -1;
		o.hit = (s >= 0);
		if (r.cmd == CMD_LOOKUP) begin
			if (lookups_total != 32'hffffffff) lookups_total++;
			if (s >= 0) o.read_value = line_val[s];
			else if (lookups_failed != 32'hffffffff) lookups_failed++;
		end else if (r.cmd == CMD_UPDATE) begin
			if (s >= 0) begin
				a = line_rank[s];
				for (int i = 0; i < SLOTS; i++)
					if (line_vld[i] && line_rank[i] < a) line_rank[i]++;
				line_rank[s] = 0;
				line_val[s] = r.write_value;
			end else begin
				if (line_cnt >= cap && line_cnt > 0) begin
					lru = -1;
					for (int i = 0; i < SLOTS; i++)
						if (line_vld[i] && (lru < 0 || line_rank[i] > line_rank[lru])) lru = i;
					if (lru >= 0) begin
						o.evicted = 1'b1;
						o.evicted_key = line_key[lru];
						drop_line(lru);
					end
				end
				fr = -1;
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!line_vld[i]) fr = i;
				if (fr >= 0) begin
					for (int j = 0; j < SLOTS; j++)
						if (line_vld[j]) line_rank[j]++;
					line_vld[fr] = 1;
					line_key[fr] = r.key;
					line_val[fr] = r.write_value;
					line_rank[fr] = 0;
					line_cnt++;
				end
			end
		end else if (r.cmd == CMD_INVAL) begin
			if (s >= 0) drop_line(s);
		end
		o.occupancy = line_cnt[6:0];
		o.request_count = lookups_total;
		o.miss_count = lookups_failed;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", 64'(rsp.hit), 64'd0);
				end else begin
					e = expected_words.pop_front();
					if (rsp.hit !== e.hit) report_mismatch("hit", 64'(rsp.hit), 64'(e.hit));
					if (rsp.read_value !== e.read_value)
						report_mismatch("read_value", rsp.read_value, e.read_value);
					if (rsp.evicted !== e.evicted)
						report_mismatch("evicted", 64'(rsp.evicted), 64'(e.evicted));
					if (rsp.evicted_key !== e.evicted_key)
						report_mismatch("evicted_key", rsp.evicted_key, e.evicted_key);
					if (rsp.occupancy !== e.occupancy)
						report_mismatch("occupancy", 64'(rsp.occupancy), 64'(e.occupancy));
					if (rsp.request_count !== e.request_count)
						report_mismatch("request_count", 64'(rsp.request_count),
							64'(e.request_count));
					if (rsp.miss_count !== e.miss_count)
						report_mismatch("miss_count", 64'(rsp.miss_count), 64'(e.miss_count));
				end
			end
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				hold_cycles <= hold_cycles + 1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_word(logic [1:0] c, logic [63:0] k, logic [63:0] v);
		req_t r;
		rsp_t w;
		r.cmd = c;
		r.key = k;
		r.write_value = v;
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		req_valid <= 1'b1;
		req <= r;
		w = cache_access(r);
		expected_words = {expected_words, w};
		@(posedge clk);
		while (req_stall) @(posedge clk);
		req_valid <= 1'b0;
		// block is busy after taking a word, so this costs no throughput
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (2 * SLOTS + 20) @(posedge clk);
	endtask

	task automatic write_capacity(logic [6:0] v);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= APB_AW'(REG_CAPACITY) << 2;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_reg = v;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_directed();
		send_word(CMD_LOOKUP, 64'd0, 64'd0);
		send_word(CMD_UPDATE, 64'd0, 64'hffffffffffffffff);
		send_word(CMD_UPDATE, 64'hffffffffffffffff, 64'd0);
		send_word(CMD_LOOKUP, 64'd0, 64'd0);
		send_word(CMD_LOOKUP, 64'hffffffffffffffff, 64'd5);
		send_word(CMD_UPDATE, 64'd0, 64'h5555aaaa5555aaaa);
		send_word(CMD_INVAL, 64'hffffffffffffffff, 64'd0);
		send_word(CMD_INVAL, 64'h1234, 64'd0);
		send_word(CMD_SPARE, 64'd0, 64'hffffffffffffffff);
		send_word(CMD_LOOKUP, 64'd0, 64'd0);
		// fill past capacity one to see eviction
		write_capacity(7'd1);
		send_word(CMD_UPDATE, 64'h77, 64'h1);
		send_word(CMD_UPDATE, 64'h78, 64'h2);
		send_word(CMD_LOOKUP, 64'h77, 64'd0);
		// zero acts as one, above depth acts as depth
		write_capacity(7'd0);
		send_word(CMD_UPDATE, 64'h79, 64'h3);
		write_capacity(7'd127);
		for (int i = 0; i < 4; i++) send_word(CMD_UPDATE, 64'(i), rand64());
		// lowered below occupancy
		write_capacity(7'd2);
		send_word(CMD_UPDATE, 64'h99, 64'h4);
		send_word(CMD_LOOKUP, 64'h2, 64'd0);
		drain();
	endtask

	task automatic test_random(int n, int idle, int stall);
		int c;
		logic [63:0] k;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < 16; i++) key_pool[i] = rand64();
		for (int i = 0; i < n; i++) begin
			c = $urandom_range(99);
			k = ($urandom_range(9) == 0) ? rand64() : key_pool[$urandom_range(15)];
			if (c < 40) send_word(CMD_LOOKUP, k, rand64());
			else if (c < 80) send_word(CMD_UPDATE, k, rand64());
			else if (c < 96) send_word(CMD_INVAL, k, rand64());
			else send_word(CMD_SPARE, k, rand64());
		end
		drain();
	endtask

	task automatic test_pressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		hold_rsp = 1'b1;
		fork
			begin
				for (int i = 0; i < 6; i++) send_word(CMD_UPDATE, 64'(i + 300), rand64());
			end
			begin
				wait (hold_cycles >= 600);
				hold_rsp = 1'b0;
			end
		join
		drain();
		// sender waits for every result before the next word
		for (int i = 0; i < 4; i++) begin
			send_word(CMD_LOOKUP, 64'(i + 300), 64'd0);
			while (expected_words.size() != 0) @(posedge clk);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycle_count = 0;
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_rsp = 1'b0;
		hold_cycles = 0;
		cap_reg = CAP_RESET;
		lookups_total = '0;
		lookups_failed = '0;
		line_cnt = 0;
		for (int i = 0; i < SLOTS; i++) begin
			line_vld[i] = 0;
			line_rank[i] = 0;
			line_key[i] = '0;
			line_val[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_capacity(7'd8);
		test_random(350, 0, 0);
		write_capacity(7'd64);
		test_random(350, 59, 0);
		write_capacity(7'd3);
		test_random(350, 0, 59);
		write_capacity(7'd12);
		test_random(350, 7, 7);
		test_pressure();
		drain();
		if (error_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule
